/* hw/rtl/srf_pkg.sv */
// Shared types and constants for the shortest route finder.
`default_nettype none
package srf_pkg;

    // Request operations
    localparam logic [1:0] OP_LOAD_EDGE  = 2'd0;
    localparam logic [1:0] OP_LOAD_MASK  = 2'd1;
    localparam logic [1:0] OP_FIND_ROUTE = 2'd2;
    localparam logic [1:0] OP_RSVD       = 2'd3;

    // Configuration register indexes
    localparam logic CFG_WEIGHT_MODE   = 1'b0;
    localparam logic CFG_STATION_COUNT = 1'b1;

    // Weight modes (the spare code behaves as hops)
    localparam logic [1:0] MODE_DISTANCE = 2'd0;
    localparam logic [1:0] MODE_TIME     = 2'd1;
    localparam logic [1:0] MODE_HOPS     = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;

    localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
    localparam int          ROUTE_MAX = 64;
    localparam int          LEN_W     = 7;
    localparam int          DIST_W    = 20;
    localparam int          DIV_STEPS = 20;
    // (5*speed)/36 computed as speed*5*1821 >> 16, exact for speed < 256
    localparam logic [21:0] SPEED_RECIP = 22'd9105;
    localparam int          RECIP_SHIFT = 16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  station_a;
        logic [5:0]  station_b;
        logic [19:0] distance_m;
        logic [7:0]  line_speed_kmh;
        logic [31:0] line_mask;
    } t_req;

    typedef struct packed {
        logic [5:0]  path_station;
        logic [31:0] total_cost;
        logic        status;
        logic        last_of_route;
    } t_rsp;

    typedef struct packed {
        logic [5:0]  ea;
        logic [5:0]  eb;
        logic [19:0] dist_m;
        logic [31:0] tw;
    } t_edge;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_DIV_INIT, S_DIV_STEP, S_EDGE_WR, S_MASK_WR,
        S_Q_INIT, S_SEL_INIT, S_SEL_RD, S_SEL_CMP, S_SEL_END, S_SETTLE,
        S_LINES_U, S_E_RD, S_E_CHK, S_H_RD, S_H_CHK, S_RELAX, S_DONE,
        S_TRACE_INIT, S_TRACE_WR, S_TRACE_NEXT, S_EMIT_RD, S_EMIT_OUT, S_FAIL
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_LATCH, DP_DIV_INIT, DP_DIV_STEP, DP_EDGE_WR, DP_MASK_WR,
        DP_Q_INIT, DP_SEL_INIT, DP_SEL_RD, DP_SEL_CMP, DP_SETTLE, DP_LINES_U,
        DP_E_RD, DP_E_CHK, DP_H_RD, DP_H_CHK, DP_RELAX, DP_COST_RD,
        DP_TRACE_INIT, DP_TRACE_WR, DP_TRACE_NEXT, DP_EMIT_RD, DP_EMIT_OUT,
        DP_FAIL_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_op;
        logic       edge_full;
        logic       range_bad;
        logic       step_last;
        logic       idx_end;
        logic       found;
        logic       hops;
        logic       edge_zero;
        logic       edge_end;
        logic       relax_go;
        logic       dst_reached;
        logic       trace_stop;
        logic       emit_end;
    } t_sts;

endpackage
`default_nettype wire

/* hw/rtl/shortest_route_finder_top.sv */
// Top level of the shortest route finder: controller plus datapath.
`default_nettype none
// Request channel: i_req is taken at a clock edge with i_start high and o_busy low.
//   Edge loads and mask loads return nothing; a find-route request returns the
//   route source first, one station per strobe on o_rsp_valid, every result
//   carrying the total cost, the last one flagged by last_of_route. An
//   unreachable destination or an out-of-range station returns one result with status 1.
// Results are strobed for one cycle each and never back to back; the receiver
//   cannot stall them.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 weight mode,
//   1 station count). Write only while o_busy is low; the block does not check it.
// Work: an edge load runs its weight through the bit-serial weight divider; a
//   query selects and settles each station reached, relaxing its neighbours,
//   then reads out one route station per result. Pace is set by one read port
//   per store: each station selection scans all n costs, n the stations in
//   use, and each settle walks all edges stored; in hop mode the edge walk is
//   replaced by a station walk.
// Reset (synchronous, active low) empties the edge store, clears all line masks
//   and sets weight mode 0 and station count 64.
module shortest_route_finder_top #(
    parameter int MAX_STATIONS = 64,
    parameter int MAX_EDGES    = 512,
    parameter int MAX_LINES    = 32
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  srf_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_rsp_valid,
    output srf_pkg::t_rsp o_rsp,
    input  wire           i_cfg_we,
    input  wire           i_cfg_idx,
    input  wire  [6:0]    i_cfg_data
);

    srf_pkg::t_cmd cmd;
    srf_pkg::t_sts sts;

    // Sequencer
    srf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // Stores and arithmetic
    srf_dp #(
        .MAX_STATIONS (MAX_STATIONS),
        .MAX_EDGES    (MAX_EDGES),
        .MAX_LINES    (MAX_LINES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule
`default_nettype wire

/* hw/rtl/srf_ctrl.sv */
// Sequencing state machine for the shortest route finder.
`default_nettype none
module srf_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  srf_pkg::t_sts i_sts,
    output srf_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    srf_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srf_pkg::S_IDLE: begin
                if (i_start) n_state = srf_pkg::S_DECODE;
            end
            srf_pkg::S_DECODE: begin
                case (i_sts.req_op)
                    srf_pkg::OP_LOAD_EDGE:
                        n_state = i_sts.edge_full ? srf_pkg::S_IDLE : srf_pkg::S_DIV_INIT;
                    srf_pkg::OP_LOAD_MASK:
                        n_state = srf_pkg::S_MASK_WR;
                    srf_pkg::OP_FIND_ROUTE:
                        n_state = i_sts.range_bad ? srf_pkg::S_FAIL : srf_pkg::S_Q_INIT;
                    default: n_state = srf_pkg::S_IDLE;
                endcase
            end
            srf_pkg::S_DIV_INIT: n_state = srf_pkg::S_DIV_STEP;
            srf_pkg::S_DIV_STEP: begin
                if (i_sts.step_last) n_state = srf_pkg::S_EDGE_WR;
            end
            srf_pkg::S_EDGE_WR:  n_state = srf_pkg::S_IDLE;
            srf_pkg::S_MASK_WR:  n_state = srf_pkg::S_IDLE;
            srf_pkg::S_Q_INIT:   n_state = srf_pkg::S_SEL_INIT;
            srf_pkg::S_SEL_INIT: n_state = srf_pkg::S_SEL_RD;
            srf_pkg::S_SEL_RD:   n_state = srf_pkg::S_SEL_CMP;
            srf_pkg::S_SEL_CMP:
                n_state = i_sts.idx_end ? srf_pkg::S_SEL_END : srf_pkg::S_SEL_RD;
            srf_pkg::S_SEL_END:
                n_state = i_sts.found ? srf_pkg::S_SETTLE : srf_pkg::S_DONE;
            srf_pkg::S_SETTLE: begin
                if (i_sts.hops) n_state = srf_pkg::S_LINES_U;
                else if (i_sts.edge_zero) n_state = srf_pkg::S_SEL_INIT;
                else n_state = srf_pkg::S_E_RD;
            end
            srf_pkg::S_LINES_U: n_state = srf_pkg::S_H_RD;
            srf_pkg::S_E_RD:    n_state = srf_pkg::S_E_CHK;
            srf_pkg::S_E_CHK: begin
                if (i_sts.relax_go) n_state = srf_pkg::S_RELAX;
                else if (i_sts.edge_end) n_state = srf_pkg::S_SEL_INIT;
                else n_state = srf_pkg::S_E_RD;
            end
            srf_pkg::S_H_RD: n_state = srf_pkg::S_H_CHK;
            srf_pkg::S_H_CHK: begin
                if (i_sts.relax_go) n_state = srf_pkg::S_RELAX;
                else if (i_sts.idx_end) n_state = srf_pkg::S_SEL_INIT;
                else n_state = srf_pkg::S_H_RD;
            end
            srf_pkg::S_RELAX: begin
                if (i_sts.hops)
                    n_state = i_sts.idx_end ? srf_pkg::S_SEL_INIT : srf_pkg::S_H_RD;
                else
                    n_state = i_sts.edge_end ? srf_pkg::S_SEL_INIT : srf_pkg::S_E_RD;
            end
            srf_pkg::S_DONE:
                n_state = i_sts.dst_reached ? srf_pkg::S_TRACE_INIT : srf_pkg::S_FAIL;
            srf_pkg::S_TRACE_INIT: n_state = srf_pkg::S_TRACE_WR;
            srf_pkg::S_TRACE_WR:
                n_state = i_sts.trace_stop ? srf_pkg::S_EMIT_RD : srf_pkg::S_TRACE_NEXT;
            srf_pkg::S_TRACE_NEXT: n_state = srf_pkg::S_TRACE_WR;
            srf_pkg::S_EMIT_RD:    n_state = srf_pkg::S_EMIT_OUT;
            srf_pkg::S_EMIT_OUT:
                n_state = i_sts.emit_end ? srf_pkg::S_IDLE : srf_pkg::S_EMIT_RD;
            srf_pkg::S_FAIL: n_state = srf_pkg::S_IDLE;
            default: n_state = srf_pkg::S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_busy = (r_state != srf_pkg::S_IDLE);
        case (r_state)
            srf_pkg::S_IDLE:       o_cmd.op = i_start ? srf_pkg::DP_LATCH : srf_pkg::DP_NOP;
            srf_pkg::S_DIV_INIT:   o_cmd.op = srf_pkg::DP_DIV_INIT;
            srf_pkg::S_DIV_STEP:   o_cmd.op = srf_pkg::DP_DIV_STEP;
            srf_pkg::S_EDGE_WR:    o_cmd.op = srf_pkg::DP_EDGE_WR;
            srf_pkg::S_MASK_WR:    o_cmd.op = srf_pkg::DP_MASK_WR;
            srf_pkg::S_Q_INIT:     o_cmd.op = srf_pkg::DP_Q_INIT;
            srf_pkg::S_SEL_INIT:   o_cmd.op = srf_pkg::DP_SEL_INIT;
            srf_pkg::S_SEL_RD:     o_cmd.op = srf_pkg::DP_SEL_RD;
            srf_pkg::S_SEL_CMP:    o_cmd.op = srf_pkg::DP_SEL_CMP;
            srf_pkg::S_SETTLE:     o_cmd.op = srf_pkg::DP_SETTLE;
            srf_pkg::S_LINES_U:    o_cmd.op = srf_pkg::DP_LINES_U;
            srf_pkg::S_E_RD:       o_cmd.op = srf_pkg::DP_E_RD;
            srf_pkg::S_E_CHK:      o_cmd.op = srf_pkg::DP_E_CHK;
            srf_pkg::S_H_RD:       o_cmd.op = srf_pkg::DP_H_RD;
            srf_pkg::S_H_CHK:      o_cmd.op = srf_pkg::DP_H_CHK;
            srf_pkg::S_RELAX:      o_cmd.op = srf_pkg::DP_RELAX;
            srf_pkg::S_DONE:       o_cmd.op = srf_pkg::DP_COST_RD;
            srf_pkg::S_TRACE_INIT: o_cmd.op = srf_pkg::DP_TRACE_INIT;
            srf_pkg::S_TRACE_WR:   o_cmd.op = srf_pkg::DP_TRACE_WR;
            srf_pkg::S_TRACE_NEXT: o_cmd.op = srf_pkg::DP_TRACE_NEXT;
            srf_pkg::S_EMIT_RD:    o_cmd.op = srf_pkg::DP_EMIT_RD;
            srf_pkg::S_EMIT_OUT:   o_cmd.op = srf_pkg::DP_EMIT_OUT;
            srf_pkg::S_FAIL:       o_cmd.op = srf_pkg::DP_FAIL_OUT;
            default:               o_cmd.op = srf_pkg::DP_NOP;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/srf_dp.sv */
// Datapath: graph stores, search state, weight divider and result register.
`default_nettype none
module srf_dp #(
    parameter int MAX_STATIONS = 64,
    parameter int MAX_EDGES    = 512,
    parameter int MAX_LINES    = 32
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  srf_pkg::t_req i_req,
    input  wire           i_cfg_we,
    input  wire           i_cfg_idx,
    input  wire  [6:0]    i_cfg_data,
    input  srf_pkg::t_cmd i_cmd,
    output srf_pkg::t_sts o_sts,
    output logic          o_rsp_valid,
    output srf_pkg::t_rsp o_rsp
);

    localparam int SW  = $clog2(MAX_STATIONS);
    localparam int NW  = $clog2(MAX_STATIONS + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int LW  = srf_pkg::LEN_W;
    localparam int PW  = $clog2(srf_pkg::ROUTE_MAX);

    // Configuration
    logic [1:0] r_weight_mode;
    logic [6:0] r_station_count;

    // Stores
    srf_pkg::t_edge      edge_mem  [MAX_EDGES];
    logic [MAX_LINES-1:0] lines_mem [MAX_STATIONS];
    logic [31:0]          cost_mem  [MAX_STATIONS];
    logic [SW-1:0]        pred_mem  [MAX_STATIONS];
    logic [SW-1:0]        path_mem  [srf_pkg::ROUTE_MAX];

    logic [MAX_STATIONS-1:0] r_lines_vld, r_reached, r_settled;
    logic [ECW-1:0]       r_edge_count, r_eidx;
    srf_pkg::t_req        r_req;
    srf_pkg::t_edge       r_edge_rd;
    logic [MAX_LINES-1:0] r_lines_rd, r_lines_u;
    logic [31:0]          r_cost_rd, r_cost_u, r_w, r_total;
    logic [SW-1:0]        r_pred_rd, r_path_rd, r_cand, r_u, r_v, r_k;
    logic [NW-1:0]        r_idx;
    logic                 r_found;
    logic [LW-1:0]        r_len;
    logic [5:0]           r_div, r_rem;
    logic [srf_pkg::DIST_W-1:0] r_quot;
    logic [4:0]           r_step;
    logic                 r_out_vld;
    srf_pkg::t_rsp        r_out;

    // Combinational helpers
    logic [NW-1:0]  n_use;
    logic [SW-1:0]  src_i, dst_i, v_i;
    logic [5:0]     v6;
    logic           e_match, e_go, h_go;
    logic [21:0]    spd_prod;
    logic [6:0]     div_trial;
    logic [32:0]    relax_sum;
    logic [31:0]    relax_cost;
    logic [LW-1:0]  len_m1;
    srf_pkg::t_edge edge_wr;

    // Stations in use, clamped to 1..MAX_STATIONS
    always_comb begin
        if (r_station_count == 7'd0) n_use = NW'(1);
        else if (int'(r_station_count) > MAX_STATIONS) n_use = NW'(MAX_STATIONS);
        else n_use = NW'(r_station_count);
    end

    assign src_i = SW'(r_req.station_a);
    assign dst_i = SW'(r_req.station_b);

    // Edge and line checks: neighbor of the settled station
    always_comb begin
        e_match = (int'(r_edge_rd.ea) == int'(r_u)) || (int'(r_edge_rd.eb) == int'(r_u));
        v6      = (int'(r_edge_rd.ea) == int'(r_u)) ? r_edge_rd.eb : r_edge_rd.ea;
        v_i     = SW'(v6);
        e_go    = e_match && (int'(v6) < int'(n_use)) && !r_settled[v_i];
        h_go    = (|(r_lines_u & r_lines_rd)) && !r_settled[r_v];
    end

    // Weight divisor and divider step
    assign spd_prod  = 22'(r_req.line_speed_kmh) * srf_pkg::SPEED_RECIP;
    assign div_trial = {r_rem, r_quot[srf_pkg::DIST_W-1]};

    always_comb begin
        edge_wr.ea     = r_req.station_a;
        edge_wr.eb     = r_req.station_b;
        edge_wr.dist_m = r_req.distance_m;
        edge_wr.tw     = (r_div == 6'd0) ? srf_pkg::SAT32 : 32'(r_quot);
    end

    // Saturating path cost
    assign relax_sum  = {1'b0, r_cost_u} + {1'b0, r_w};
    assign relax_cost = relax_sum[32] ? srf_pkg::SAT32 : relax_sum[31:0];
    assign len_m1     = r_len - LW'(1);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_mode   <= srf_pkg::MODE_DISTANCE;
            r_station_count <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srf_pkg::CFG_WEIGHT_MODE:   r_weight_mode   <= i_cfg_data[1:0];
                srf_pkg::CFG_STATION_COUNT: r_station_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_lines_vld  <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_out_vld <= (i_cmd.op == srf_pkg::DP_EMIT_OUT) ||
                         (i_cmd.op == srf_pkg::DP_FAIL_OUT);
            if (i_cmd.op == srf_pkg::DP_EDGE_WR) r_edge_count <= r_edge_count + ECW'(1);
            if (i_cmd.op == srf_pkg::DP_MASK_WR && int'(r_req.station_a) < MAX_STATIONS)
                r_lines_vld[SW'(r_req.station_a)] <= 1'b1;
        end
    end

    // Edge store
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == srf_pkg::DP_EDGE_WR) edge_mem[r_edge_count[EW-1:0]] <= edge_wr;
        r_edge_rd <= edge_mem[r_eidx[EW-1:0]];
    end

    // Line mask store
    always_ff @(posedge i_clk) begin
        logic [SW-1:0] la;
        la = (i_cmd.op == srf_pkg::DP_SETTLE) ? r_u : r_idx[SW-1:0];
        if (i_cmd.op == srf_pkg::DP_MASK_WR && int'(r_req.station_a) < MAX_STATIONS)
            lines_mem[SW'(r_req.station_a)] <= MAX_LINES'(r_req.line_mask);
        r_lines_rd <= r_lines_vld[la] ? lines_mem[la] : '0;
    end

    // Cost store
    always_ff @(posedge i_clk) begin
        logic [SW-1:0] ca;
        case (i_cmd.op)
            srf_pkg::DP_E_CHK:   ca = v_i;
            srf_pkg::DP_H_CHK:   ca = r_v;
            srf_pkg::DP_COST_RD: ca = dst_i;
            default:             ca = r_idx[SW-1:0];
        endcase
        if (i_cmd.op == srf_pkg::DP_Q_INIT) cost_mem[src_i] <= 32'd0;
        else if (i_cmd.op == srf_pkg::DP_RELAX &&
                 (!r_reached[r_v] || relax_cost < r_cost_rd))
            cost_mem[r_v] <= relax_cost;
        r_cost_rd <= cost_mem[ca];
    end

    // Predecessor and path stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == srf_pkg::DP_RELAX && (!r_reached[r_v] || relax_cost < r_cost_rd))
            pred_mem[r_v] <= r_u;
        r_pred_rd <= pred_mem[r_k];
        if (i_cmd.op == srf_pkg::DP_TRACE_WR) path_mem[r_len[PW-1:0]] <= r_k;
        r_path_rd <= path_mem[len_m1[PW-1:0]];
    end

    // Search and sequencing registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            srf_pkg::DP_LATCH: r_req <= i_req;
            srf_pkg::DP_DIV_INIT: begin
                r_div  <= spd_prod[21:srf_pkg::RECIP_SHIFT];
                r_rem  <= 6'd0;
                r_quot <= r_req.distance_m;
                r_step <= 5'd0;
            end
            srf_pkg::DP_DIV_STEP: begin
                if (div_trial >= {1'b0, r_div}) begin
                    r_rem  <= 6'(div_trial - {1'b0, r_div});
                    r_quot <= {r_quot[srf_pkg::DIST_W-2:0], 1'b1};
                end else begin
                    r_rem  <= div_trial[5:0];
                    r_quot <= {r_quot[srf_pkg::DIST_W-2:0], 1'b0};
                end
                r_step <= r_step + 5'd1;
            end
            srf_pkg::DP_Q_INIT: begin
                // only the source starts out reached
                r_reached <= MAX_STATIONS'(1) << src_i;
                r_settled <= '0;
            end
            srf_pkg::DP_SEL_INIT: begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            srf_pkg::DP_SEL_RD: begin
                r_cand <= r_idx[SW-1:0];
                r_idx  <= r_idx + NW'(1);
            end
            srf_pkg::DP_SEL_CMP: begin
                if (r_reached[r_cand] && !r_settled[r_cand] &&
                    (!r_found || r_cost_rd < r_cost_u)) begin
                    r_u      <= r_cand;
                    r_cost_u <= r_cost_rd;
                    r_found  <= 1'b1;
                end
            end
            srf_pkg::DP_SETTLE: begin
                r_settled[r_u] <= 1'b1;
                r_idx          <= '0;
                r_eidx         <= '0;
            end
            srf_pkg::DP_LINES_U: r_lines_u <= r_lines_rd;
            srf_pkg::DP_E_RD:    r_eidx    <= r_eidx + ECW'(1);
            srf_pkg::DP_E_CHK: begin
                r_v <= v_i;
                r_w <= (r_weight_mode == srf_pkg::MODE_TIME) ? r_edge_rd.tw
                                                             : 32'(r_edge_rd.dist_m);
            end
            srf_pkg::DP_H_RD: begin
                r_v   <= r_idx[SW-1:0];
                r_w   <= 32'd1;
                r_idx <= r_idx + NW'(1);
            end
            srf_pkg::DP_RELAX: begin
                if (!r_reached[r_v] || relax_cost < r_cost_rd) r_reached[r_v] <= 1'b1;
            end
            srf_pkg::DP_TRACE_INIT: begin
                r_total <= r_cost_rd;
                r_k     <= dst_i;
                r_len   <= '0;
            end
            srf_pkg::DP_TRACE_WR:   r_len <= r_len + LW'(1);
            srf_pkg::DP_TRACE_NEXT: r_k   <= r_pred_rd;
            srf_pkg::DP_EMIT_RD:    r_len <= len_m1;
            srf_pkg::DP_EMIT_OUT: begin
                r_out.path_station  <= 6'(r_path_rd);
                r_out.total_cost    <= r_total;
                r_out.status        <= 1'b0;
                r_out.last_of_route <= (r_len == '0);
            end
            srf_pkg::DP_FAIL_OUT: begin
                r_out.path_station  <= 6'd0;
                r_out.total_cost    <= 32'd0;
                r_out.status        <= 1'b1;
                r_out.last_of_route <= 1'b1;
            end
            default: ;
        endcase
    end

    // Status to the controller
    always_comb begin
        o_sts.req_op      = r_req.operation;
        o_sts.edge_full   = (r_edge_count == ECW'(MAX_EDGES));
        o_sts.range_bad   = (int'(r_req.station_a) >= int'(n_use)) ||
                            (int'(r_req.station_b) >= int'(n_use));
        o_sts.step_last   = (r_step == 5'(srf_pkg::DIV_STEPS - 1));
        o_sts.idx_end     = (r_idx == n_use);
        o_sts.found       = r_found;
        o_sts.hops        = r_weight_mode[1];
        o_sts.edge_zero   = (r_edge_count == '0);
        o_sts.edge_end    = (r_eidx == r_edge_count);
        o_sts.relax_go    = (i_cmd.op == srf_pkg::DP_E_CHK) ? e_go : h_go;
        o_sts.dst_reached = r_reached[dst_i];
        o_sts.trace_stop  = (int'(r_k) == int'(r_req.station_a)) ||
                            (r_len == LW'(srf_pkg::ROUTE_MAX - 1));
        o_sts.emit_end    = (r_len == '0);
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

`ifndef SYNTH
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(i_cmd.op) == srf_pkg::DP_EMIT_OUT ||
                              $past(i_cmd.op) == srf_pkg::DP_FAIL_OUT))
        else $error("result strobe without an emit command");
    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_edge_count) <= MAX_EDGES)
        else $error("edge count beyond store depth");
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status) |-> r_out.last_of_route)
        else $error("unreachable result not marked last");
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == srf_pkg::DP_EDGE_WR) |-> !o_sts.edge_full)
        else $error("edge write into full store");
`endif

endmodule
`default_nettype wire

/* dv/srf_route_checker.sv */
// Checker for the shortest route finder: mirrors state, predicts routes, compares results.
`default_nettype none
module srf_route_checker (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire           i_busy,
    input  srf_pkg::t_req i_req,
    input  wire           i_rsp_valid,
    input  srf_pkg::t_rsp i_rsp,
    input  wire           i_cfg_we,
    input  wire           i_cfg_idx,
    input  wire  [6:0]    i_cfg_data,
    output int            o_errors,
    output int            o_pending,
    output int            o_accepted
);

    localparam int NST = 64;
    localparam int NEDGE = 512;

    logic [1:0]    mode;
    logic [6:0]    nst_cfg;
    logic [5:0]    e_a [NEDGE];
    logic [5:0]    e_b [NEDGE];
    logic [19:0]   e_dist [NEDGE];
    logic [7:0]    e_speed [NEDGE];
    int            n_edges;
    logic [31:0]   lines [NST];
    srf_pkg::t_rsp route_q [$];
    int            errors;

    assign o_errors = errors;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        errors++;
    endtask

    // Dijkstra with lowest-index tie break, strict-less relaxation
    task automatic predict_route(input logic [5:0] src, input logic [5:0] dst);
        int            n;
        logic [31:0]   cost [NST];
        bit            seen [NST];
        bit            done [NST];
        int            prev [NST];
        int            path [$];
        int            u, k;
        bit            found;
        logic [31:0]   w, c, dv;
        srf_pkg::t_rsp r;
        n = (nst_cfg == 0) ? 1 : (nst_cfg > NST ? NST : int'(nst_cfg));
        if (src >= n || dst >= n) begin
            r = '{path_station: 6'd0, total_cost: 32'd0, status: 1'b1, last_of_route: 1'b1};
            route_q.push_back(r);
            return;
        end
        for (int i = 0; i < NST; i++) begin
            cost[i] = 0; seen[i] = 0; done[i] = 0; prev[i] = 0;
        end
        seen[src] = 1;
        forever begin
            found = 0; u = 0;
            for (int i = 0; i < n; i++)
                if (seen[i] && !done[i] && (!found || cost[i] < cost[u])) begin
                    u = i; found = 1;
                end
            if (!found) break;
            done[u] = 1;
            for (int j = 0; j < (mode >= srf_pkg::MODE_HOPS ? n : n_edges * 2); j++) begin
                int v;
                if (mode >= srf_pkg::MODE_HOPS) begin
                    if ((lines[u] & lines[j]) == 0) continue;
                    v = j; w = 32'd1;
                end else begin
                    int e;
                    e = j / 2;
                    if ((j % 2) == 0) begin
                        if (e_a[e] != u) continue;
                        v = e_b[e];
                    end else begin
                        if (e_b[e] != u) continue;
                        v = e_a[e];
                    end
                    w = 32'(e_dist[e]);
                    if (mode == srf_pkg::MODE_TIME) begin
                        dv = (32'd5 * 32'(e_speed[e])) / 32'd36;
                        w = (dv == 0) ? srf_pkg::SAT32 : w / dv;
                    end
                end
                if (v >= n || done[v]) continue;
                c = cost[u] + w;
                if (c < cost[u]) c = srf_pkg::SAT32;
                if (!seen[v] || c < cost[v]) begin
                    cost[v] = c; seen[v] = 1; prev[v] = u;
                end
            end
        end
        if (!seen[dst]) begin
            r = '{path_station: 6'd0, total_cost: 32'd0, status: 1'b1, last_of_route: 1'b1};
            route_q.push_back(r);
            return;
        end
        k = dst;
        while (path.size() < srf_pkg::ROUTE_MAX) begin
            path.push_front(k);
            if (k == src) break;
            k = prev[k];
        end
        foreach (path[i]) begin
            r.path_station  = 6'(path[i]);
            r.total_cost    = cost[dst];
            r.status        = 1'b0;
            r.last_of_route = (i == path.size() - 1);
            route_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        srf_pkg::t_rsp exp_r;
        if (!i_rst_n) begin
            mode <= srf_pkg::MODE_DISTANCE; nst_cfg <= 7'd64; n_edges = 0; errors = 0;
            o_accepted <= 0;
            o_pending  <= 0;
            for (int i = 0; i < NST; i++) lines[i] = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == srf_pkg::CFG_WEIGHT_MODE) mode <= i_cfg_data[1:0];
                else nst_cfg <= i_cfg_data;
            end
            // result side
            if (i_rsp_valid) begin
                if (route_q.size() == 0) report_mismatch("result with none expected");
                else begin
                    exp_r = route_q.pop_front();
                    if (i_rsp.path_station !== exp_r.path_station)
                        report_mismatch($sformatf("station %0d exp %0d",
                            i_rsp.path_station, exp_r.path_station));
                    if (i_rsp.total_cost !== exp_r.total_cost)
                        report_mismatch($sformatf("cost %0d exp %0d",
                            i_rsp.total_cost, exp_r.total_cost));
                    if (i_rsp.status !== exp_r.status)
                        report_mismatch($sformatf("status %0b exp %0b",
                            i_rsp.status, exp_r.status));
                    if (i_rsp.last_of_route !== exp_r.last_of_route)
                        report_mismatch($sformatf("last %0b exp %0b",
                            i_rsp.last_of_route, exp_r.last_of_route));
                end
            end
            // request side
            if (i_start && !i_busy) begin
                o_accepted <= o_accepted + 1;
                case (i_req.operation)
                    srf_pkg::OP_LOAD_EDGE: if (n_edges < NEDGE) begin
                        e_a[n_edges] = i_req.station_a;
                        e_b[n_edges] = i_req.station_b;
                        e_dist[n_edges] = i_req.distance_m;
                        e_speed[n_edges] = i_req.line_speed_kmh;
                        n_edges++;
                    end
                    srf_pkg::OP_LOAD_MASK: lines[i_req.station_a] = i_req.line_mask;
                    srf_pkg::OP_FIND_ROUTE: predict_route(i_req.station_a, i_req.station_b);
                    default: ;
                endcase
            end
            o_pending <= route_q.size();
        end
    end
endmodule
`default_nettype wire

/* dv/tb_shortest_route_finder_top.sv */
// Testbench top for the shortest route finder: stimulus, configuration phases and verdict.
`default_nettype none
module tb_shortest_route_finder_top;

    localparam int WATCH_LIMIT = 2000000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    srf_pkg::t_req req = '0;
    logic          busy;
    logic          rsp_valid;
    srf_pkg::t_rsp rsp;
    logic          cfg_we = 1'b0;
    logic          cfg_idx = 1'b0;
    logic [6:0]    cfg_data = '0;
    int            errors, pending, accepted;
    int            quiet_cycles = 0;
    int            last_acc = 0;
    bit            no_idle = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    shortest_route_finder_top DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_req(req), .o_busy(busy),
        .o_rsp_valid(rsp_valid), .o_rsp(rsp), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    srf_route_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy), .i_req(req),
        .i_rsp_valid(rsp_valid), .i_rsp(rsp), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending),
        .o_accepted(accepted)
    );

    // watchdog: cycles with no request and no result accepted
    always @(posedge clk) begin
        if (rsp_valid || accepted != last_acc) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        last_acc <= accepted;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("tb_shortest_route_finder_top: errors");
            $finish;
        end
    end

    // one request: optional idle burst, then hold start until taken
    task automatic send_req(input srf_pkg::t_req r);
        int gap;
        if (!no_idle && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        // block is busy for at least this cycle after taking a request
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (pending != 0 || busy) @(posedge clk);
        repeat (40) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [6:0] val);
        wait_idle();
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic srf_pkg::t_req mk(input logic [1:0] op, input logic [5:0] a,
                                         input logic [5:0] b, input logic [19:0] d,
                                         input logic [7:0] s, input logic [31:0] m);
        srf_pkg::t_req r;
        r = '{operation: op, station_a: a, station_b: b, distance_m: d,
              line_speed_kmh: s, line_mask: m};
        return r;
    endfunction

    function automatic logic [5:0] rnd_st(input int hi);
        return 6'($urandom_range(0, hi));
    endfunction

    // mostly in-range loads and queries over stations 0..span, plus a few reserved requests
    task automatic random_phase(input int items, input int span);
        int p;
        for (int i = 0; i < items; i++) begin
            p = $urandom_range(0, 99);
            if (p < 40)
                send_req(mk(srf_pkg::OP_LOAD_EDGE, rnd_st(span), rnd_st(span),
                    ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                : 20'($urandom_range(0, 5000)),
                    8'($urandom), 32'd0));
            else if (p < 55)
                send_req(mk(srf_pkg::OP_LOAD_MASK, ($urandom_range(0, 9) == 0) ? rnd_st(63)
                    : rnd_st(span), 6'd0, 20'd0, 8'd0,
                    (32'd1 << $urandom_range(0, 31)) |
                    (($urandom_range(0, 1) != 0) ? $urandom : 32'd0)));
            else if (p < 95)
                send_req(mk(srf_pkg::OP_FIND_ROUTE, ($urandom_range(0, 9) == 0) ? rnd_st(63)
                    : rnd_st(span), rnd_st(span), 20'($urandom), 8'($urandom), $urandom));
            else
                send_req(mk(srf_pkg::OP_RSVD, 6'($urandom), 6'($urandom), 20'($urandom),
                    8'($urandom), $urandom));
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small graph with saturating, zero-speed and tie cases
        write_cfg(srf_pkg::CFG_STATION_COUNT, 7'd8);
        // no edges yet: unreachable
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd0, 6'd1, 20'd0, 8'd0, 32'd0));
        send_req(mk(srf_pkg::OP_LOAD_EDGE, 6'd0, 6'd1, 20'hFFFFF, 8'hFF, 32'd0));
        send_req(mk(srf_pkg::OP_LOAD_EDGE, 6'd1, 6'd2, 20'd10, 8'd0, 32'd0));
        send_req(mk(srf_pkg::OP_LOAD_EDGE, 6'd0, 6'd2, 20'd0, 8'd7, 32'd0));
        // end beyond the station count
        send_req(mk(srf_pkg::OP_LOAD_EDGE, 6'd2, 6'd63, 20'd5, 8'd80, 32'd0));
        send_req(mk(srf_pkg::OP_LOAD_EDGE, 6'd3, 6'd2, 20'd5, 8'd80, 32'd0));
        send_req(mk(srf_pkg::OP_LOAD_MASK, 6'd0, 6'd0, 20'd0, 8'd0, 32'h8000_0001));
        send_req(mk(srf_pkg::OP_LOAD_MASK, 6'd5, 6'd0, 20'd0, 8'd0, 32'h0000_0001));
        send_req(mk(srf_pkg::OP_LOAD_MASK, 6'd63, 6'd0, 20'd0, 8'd0, 32'hFFFF_FFFF));
        send_req(mk(srf_pkg::OP_RSVD, 6'd1, 6'd2, 20'd0, 8'd0, 32'd0));
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd0, 6'd3, 20'd0, 8'd0, 32'd0));
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd2, 6'd2, 20'd0, 8'd0, 32'd0));
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd0, 6'd63, 20'd0, 8'd0, 32'd0));
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd63, 6'd0, 20'd0, 8'd0, 32'd0));
        write_cfg(srf_pkg::CFG_WEIGHT_MODE, 7'(srf_pkg::MODE_TIME));
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd1, 6'd3, 20'd0, 8'd0, 32'd0));
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd0, 6'd1, 20'd0, 8'd0, 32'd0));
        write_cfg(srf_pkg::CFG_WEIGHT_MODE, 7'(srf_pkg::MODE_HOPS));
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd0, 6'd5, 20'd0, 8'd0, 32'd0));
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd0, 6'd4, 20'd0, 8'd0, 32'd0));
        write_cfg(srf_pkg::CFG_WEIGHT_MODE, 7'(srf_pkg::MODE_SPARE));
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd5, 6'd0, 20'd0, 8'd0, 32'd0));
        write_cfg(srf_pkg::CFG_STATION_COUNT, 7'd0);
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd0, 6'd0, 20'd0, 8'd0, 32'd0));
        write_cfg(srf_pkg::CFG_STATION_COUNT, 7'd127);
        write_cfg(srf_pkg::CFG_WEIGHT_MODE, 7'(srf_pkg::MODE_DISTANCE));
        send_req(mk(srf_pkg::OP_FIND_ROUTE, 6'd0, 6'd3, 20'd0, 8'd0, 32'd0));

        // random phases over several settings
        write_cfg(srf_pkg::CFG_STATION_COUNT, 7'd10);
        random_phase(30, 11);
        write_cfg(srf_pkg::CFG_WEIGHT_MODE, 7'(srf_pkg::MODE_TIME));
        random_phase(25, 11);
        write_cfg(srf_pkg::CFG_WEIGHT_MODE, 7'(srf_pkg::MODE_HOPS));
        write_cfg(srf_pkg::CFG_STATION_COUNT, 7'd12);
        random_phase(25, 13);
        write_cfg(srf_pkg::CFG_WEIGHT_MODE, 7'(srf_pkg::MODE_DISTANCE));
        write_cfg(srf_pkg::CFG_STATION_COUNT, 7'd64);
        no_idle = 1;
        random_phase(39, 63);

        wait_idle();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb_shortest_route_finder_top: clean");
        else
            $display("tb_shortest_route_finder_top: errors");
        $finish;
    end
endmodule
`default_nettype wire
